### src/mdc_pkg.sv
// Shared types and constants for the modulated delay chorus.
// No dependencies; every other source file refers to this package by scoped names.
package mdc_pkg;

  // Delay line geometry (power-of-two depth)
  localparam int LINE_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int SAMPLE_W   = 24;

  // Sweep arithmetic
  localparam int PHASE_W = 32;
  localparam int STEP_W  = 31;
  localparam int DEPTH_W = 20;
  localparam int TRI_W   = 17;  // triangle in Q0.16, range 0..65536
  localparam int FRAC_W  = 8;   // fraction bits of the delay
  localparam int DELAY_W = 20;  // delay in samples, Q12.8
  localparam int DINT_W  = DELAY_W - FRAC_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DEPTH = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0]  PHASE_STEP_RST  = STEP_W'(614419);
  localparam logic [DEPTH_W-1:0] SWEEP_DEPTH_RST = DEPTH_W'(10445);

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

### src/mdc_line_ram.sv
// Delay line storage: one write port and one read port, registered read data.
// Depends on mdc_pkg for the address and sample widths.
module mdc_line_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [mdc_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [mdc_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [mdc_pkg::ADDR_W-1:0]   raddr_i,
  output logic [mdc_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [mdc_pkg::SAMPLE_W-1:0] mem [mdc_pkg::LINE_DEPTH];
  logic [mdc_pkg::SAMPLE_W-1:0] rdata_q;

  // Write the new sample
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/mdc_sweep.sv
// Sweep generator: configuration registers, phase accumulator, triangle and
// depth scaling into a Q12.8 delay. Depends on mdc_pkg.
module mdc_sweep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mdc_pkg::cfg_wr_t            cfg_i,
  input  logic                        adv_i,
  output logic [mdc_pkg::DELAY_W-1:0] delay_o
);

  localparam int PROD_W = mdc_pkg::TRI_W + mdc_pkg::DEPTH_W;

  logic [mdc_pkg::PHASE_W-1:0] phase_q;
  logic [mdc_pkg::STEP_W-1:0]  step_q;
  logic [mdc_pkg::DEPTH_W-1:0] depth_q;
  logic [mdc_pkg::TRI_W-1:0]   tri_d, tri_q;
  logic [mdc_pkg::TRI_W-1:0]   t_w;
  logic [PROD_W-1:0]           prod_w;
  logic [mdc_pkg::DELAY_W-1:0] delay_q;

  // Hold configuration; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= mdc_pkg::PHASE_STEP_RST;
      depth_q <= mdc_pkg::SWEEP_DEPTH_RST;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        mdc_pkg::REG_PHASE_STEP:  step_q  <= cfg_i.data[mdc_pkg::STEP_W-1:0];
        mdc_pkg::REG_SWEEP_DEPTH: depth_q <= cfg_i.data[mdc_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Fold the top bits of the phase into a triangle (131072 - t on the way down)
  assign t_w   = phase_q[mdc_pkg::PHASE_W-1 -: mdc_pkg::TRI_W];
  assign tri_d = t_w[mdc_pkg::TRI_W-1] ? (~t_w + 1'b1) : t_w;

  // Sample the triangle and advance the phase once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_q + mdc_pkg::PHASE_W'(step_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tri_q <= tri_d;
    end
  end

  // Scale by depth; the product is ready in the cycle after the request
  assign prod_w = PROD_W'(tri_q) * PROD_W'(depth_q);

  always_ff @(posedge clk_i) begin
    delay_q <= prod_w[16 +: mdc_pkg::DELAY_W];
  end

  assign delay_o = delay_q;

endmodule

### src/modulated_delay_chorus_top.sv
// Modulated delay chorus: sequencer, delay line access and interpolating mixer.
// Depends on mdc_pkg, mdc_sweep and mdc_line_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / sample_in_i) takes one signed
//   sample per request. Output channel (out_valid_o / out_stall_i /
//   sample_out_o) returns one mixed sample per request, in order.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
//   clock edge; index 0 is the phase step, index 1 the sweep depth. Write only
//   while no request is in flight.
//   Sequence: a taken request passes through MUL, RD0, RD1 and MIX; the
//   result is loaded into the output register at the end of MIX, once the
//   output register is free.
//   Pacing: a new sample is taken only in IDLE, after the previous one has
//   left MIX, as the single read port of the delay line (two reads per
//   sample) follows the sweep multiply; an output stall holds MIX.
//   Reset: asynchronous, active low. The phase, write pointer and config
//   return to their defaults. The delay line is not swept; a fill pointer
//   makes entries not yet written since reset read as zero.
//   Stall: while out_stall_i holds a result, one more request can be taken
//   and completed up to the mixer, where it waits for the output register.
module modulated_delay_chorus_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mdc_pkg::SAMPLE_W-1:0]   sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mdc_pkg::SAMPLE_W-1:0]   sample_out_o,
  input  logic                           cfg_we_i,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW     = mdc_pkg::SAMPLE_W;
  localparam int AW     = mdc_pkg::ADDR_W;
  localparam int FW     = mdc_pkg::FRAC_W;
  localparam int DIFF_W = SW + 1;
  localparam int MUL_W  = DIFF_W + FW + 1;
  localparam int SUM_W  = MUL_W + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RD0  = 3'd2;
  localparam logic [2:0] ST_RD1  = 3'd3;
  localparam logic [2:0] ST_MIX  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic          in_acc, out_go;
  logic [AW-1:0] wp_q;
  logic          wrapped_q;
  logic [AW-1:0] w_q;
  logic [SW-1:0] dry_q;
  logic [mdc_pkg::DELAY_W-1:0] delay_w;
  mdc_pkg::cfg_wr_t cfg_w;

  logic [AW-1:0] off_w, base_d, base_q, raddr_w;
  logic [FW-1:0] dfr_w, fr_d, fr_q;
  logic          re_w, rd_ok_d, rd_ok_q;
  logic [SW-1:0] ram_rdata, rdata_w, s0_q;

  logic signed [DIFF_W-1:0] diff_w;
  logic signed [MUL_W-1:0]  mul_w;
  logic signed [SUM_W-1:0]  sum_w;

  logic          out_valid_q;
  logic [SW-1:0] out_q;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_go     = !out_valid_q || !out_stall_i;

  assign cfg_w.we   = cfg_we_i;
  assign cfg_w.idx  = cfg_idx_i;
  assign cfg_w.data = cfg_data_i;

  mdc_sweep u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_w),
    .adv_i   (in_acc),
    .delay_o (delay_w)
  );

  // Sequence one request through multiply, two reads and the mix
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MUL;
      ST_MUL:  state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_MIX;
      ST_MIX:  if (out_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the write pointer; remember once the whole line has been written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (in_acc) begin
      wp_q <= wp_q + 1'b1;
      if (wp_q == AW'(mdc_pkg::LINE_DEPTH - 1)) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q   <= wp_q;
      dry_q <= sample_in_i;
    end
  end

  // Base entry and interpolation weight from the delay
  assign off_w  = AW'(delay_w[mdc_pkg::DELAY_W-1:FW]);
  assign dfr_w  = delay_w[FW-1:0];
  assign base_d = w_q - off_w - AW'(dfr_w != '0);
  assign fr_d   = (dfr_w == '0) ? '0 : (~dfr_w + 1'b1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD0) begin
      base_q <= base_d;
      fr_q   <= fr_d;
    end
  end

  // Read base in RD0, base + 1 in RD1; flag entries never written
  assign re_w    = (state_q == ST_RD0) || (state_q == ST_RD1);
  assign raddr_w = (state_q == ST_RD0) ? base_d : (base_q + 1'b1);
  assign rd_ok_d = wrapped_q || (raddr_w < wp_q);

  always_ff @(posedge clk_i) begin
    if (re_w) begin
      rd_ok_q <= rd_ok_d;
    end
  end

  mdc_line_ram u_line (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (sample_in_i),
    .re_i    (re_w),
    .raddr_i (raddr_w),
    .rdata_o (ram_rdata)
  );

  assign rdata_w = rd_ok_q ? ram_rdata : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD1) begin
      s0_q <= rdata_w;
    end
  end

  // Mix: 256*(dry + s0) + fr*(s1 - s0), floored by 512
  assign diff_w = DIFF_W'($signed(rdata_w)) - DIFF_W'($signed(s0_q));
  assign mul_w  = $signed({1'b0, fr_q}) * diff_w;
  assign sum_w  = (SUM_W'($signed(dry_q)) + SUM_W'($signed(s0_q))) * SUM_W'(256)
                + SUM_W'(mul_w);

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_MIX && out_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MIX && out_go) begin
      out_q <= sum_w[FW+1 +: SW];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // A result appears only from the mix step
  a_out_from_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_MIX))
    else $error("result raised outside the mix step");

  // A taken request starts the sweep multiply next
  a_acc_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MUL))
    else $error("request not followed by multiply step");

  // The write pointer moves by one per request
  a_wp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (wp_q == $past(wp_q) + 1'b1))
    else $error("write pointer did not advance");

endmodule
